FILE: rtl/core/cial_pkg.sv
`timescale 1ns / 1ps

package cial_pkg;

    // defaults for the top level parameters
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ID_BYTES_DEF    = 4;

    // event codes of a result transaction
    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_GRANTED     = 4'd1,
        EV_DENIED      = 4'd2,
        EV_NOT_MASTER  = 4'd3,
        EV_ENTER_PROG  = 4'd4,
        EV_ADDED       = 4'd5,
        EV_DELETED     = 4'd6,
        EV_FULL        = 4'd7,
        EV_MASTER_PROT = 4'd8,
        EV_ENROLLED    = 4'd9,
        EV_LEFT_PROG   = 4'd10,
        EV_FORGOTTEN   = 4'd11
    } evt_t;

    typedef enum logic [1:0] {
        MODE_UNENROLLED = 2'd0,
        MODE_NORMAL     = 2'd1,
        MODE_AWAIT      = 2'd2,
        MODE_PROG       = 2'd3
    } mode_t;

    // search token walking down the cell row
    typedef struct packed {
        logic tok;
        logic found;
    } scan_t;

    // table update broadcast to every cell
    typedef struct packed {
        logic shift;
        logic append;
    } cmd_t;

endpackage

FILE: rtl/core/cial_cell.sv
`timescale 1ns / 1ps

module cial_cell
    import cial_pkg::*;
#(
    parameter int ID_W = 32,
    parameter int CW   = 7,
    parameter int IDX  = 0
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  scan_t           scan_in,
    output scan_t           scan_out,
    input  logic [ID_W-1:0] key,
    input  logic [CW-1:0]   count,
    input  cmd_t            cmd,
    input  logic [ID_W-1:0] next_entry,
    output logic [ID_W-1:0] entry
);

    logic [ID_W-1:0] entry_reg;
    logic [ID_W-1:0] entry_next;
    logic            mark_reg;
    logic            mark_next;
    scan_t           scan_reg;
    scan_t           scan_next;
    logic            in_range;
    logic            has_next;
    logic            match;

    always_comb
    begin
        in_range        = CW'(IDX) < count;
        has_next        = CW'(IDX + 1) < count;
        match           = scan_in.tok && in_range && (entry_reg == key);
        scan_next.tok   = scan_in.tok;
        scan_next.found = scan_in.found | match;
        // mark cells at or after the first hit
        mark_next       = scan_in.tok ? scan_next.found : mark_reg;
        if (cmd.shift && mark_reg && has_next)
        begin
            entry_next = next_entry;
        end
        else if (cmd.append && (count == CW'(IDX)))
        begin
            entry_next = key;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            mark_reg <= mark_next;
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign scan_out = scan_reg;
    assign entry    = entry_reg;

endmodule

FILE: rtl/core/card_id_access_list.sv
`timescale 1ns / 1ps
// channel   | direction | content
// s_axis    | in        | tuser: card_present; tdata: card_id, program_switch, forget_switch
// m_axis    | out       | tdata: event_code, entries_now, table_full, mode_now
//
// an item is handled in steps: a search while a token walks the row of cells, one cell
// per cycle, then a step to decide and update, then a return to idle; a new item is
// taken only in idle, so no new item enters before the result of the last one is offered
// rst_n clears mode, count, master and the result valid flag; table entries are
// not cleared, only entries below the count are ever looked at
// a stalled result register holds the decision step until m_axis_tready

module card_id_access_list
    import cial_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ID_BYTES    = ID_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // card_id[31:0], program_switch[32], forget_switch[33]
    input  logic        s_axis_tuser,   // card_present[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // event_code[3:0], entries_now[10:4], table_full[11],
                                        // mode_now[13:12]
);

    // only the low ID_BYTES bytes of an id, at most four, are kept and compared
    localparam int ID_W = (ID_BYTES >= 4) ? 32 : ID_BYTES * 8;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    mode_t           mode_reg, mode_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [ID_W-1:0] master_reg, master_next;
    logic            start_reg, start_next;
    logic            found_reg, found_next;

    // captured transaction
    logic [ID_W-1:0] id_reg;
    logic            present_reg;
    logic            prog_reg;
    logic            forget_reg;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     out_data_reg, out_data_next;

    cmd_t            cmd;
    evt_t            ev;
    logic            in_take;
    logic            out_free;
    logic            is_master;

    scan_t           scan_w [TABLE_DEPTH+1];
    logic [ID_W-1:0] entry_w [TABLE_DEPTH];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_master     = (id_reg == master_reg);

    // row of cells, token enters at cell 0
    assign scan_w[0] = '{tok: start_reg, found: 1'b0};

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0] nxt;
        if (i + 1 < TABLE_DEPTH)
        begin : g_mid
            assign nxt = entry_w[i+1];
        end
        else
        begin : g_end
            assign nxt = '0;
        end
        cial_cell #(
            .ID_W (ID_W),
            .CW   (CW),
            .IDX  (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .scan_in    (scan_w[i]),
            .scan_out   (scan_w[i+1]),
            .key        (id_reg),
            .count      (count_reg),
            .cmd        (cmd),
            .next_entry (nxt),
            .entry      (entry_w[i])
        );
    end

    // decision for the captured transaction
    always_comb
    begin
        ev          = EV_NONE;
        mode_next   = mode_reg;
        count_next  = count_reg;
        master_next = master_reg;
        cmd         = '0;

        unique case (mode_reg)
            MODE_UNENROLLED:
            begin
                if (present_reg)
                begin
                    cmd.append  = 1'b1;
                    master_next = id_reg;
                    count_next  = CW'(1);
                    mode_next   = MODE_NORMAL;
                    ev          = EV_ENROLLED;
                end
            end
            MODE_NORMAL, MODE_AWAIT:
            begin
                if (prog_reg)
                begin
                    // waiting for the master card
                    mode_next = MODE_AWAIT;
                    if (present_reg)
                    begin
                        if (is_master)
                        begin
                            mode_next = MODE_PROG;
                            ev        = EV_ENTER_PROG;
                        end
                        else
                        begin
                            ev = EV_NOT_MASTER;
                        end
                    end
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    if (forget_reg)
                    begin
                        count_next  = '0;
                        master_next = '0;
                        mode_next   = MODE_UNENROLLED;
                        ev          = EV_FORGOTTEN;
                    end
                    else if (present_reg)
                    begin
                        ev = found_reg ? EV_GRANTED : EV_DENIED;
                    end
                end
            end
            MODE_PROG:
            begin
                if (present_reg)
                begin
                    mode_next = prog_reg ? MODE_AWAIT : MODE_NORMAL;
                    if (found_reg)
                    begin
                        if (is_master)
                        begin
                            ev = EV_MASTER_PROT;
                        end
                        else
                        begin
                            // compact: later entries move down one cell
                            cmd.shift  = 1'b1;
                            count_next = count_reg - CW'(1);
                            ev         = EV_DELETED;
                        end
                    end
                    else if (count_reg >= CW'(TABLE_DEPTH))
                    begin
                        ev = EV_FULL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        count_next = count_reg + CW'(1);
                        ev         = EV_ADDED;
                    end
                end
                else if (!prog_reg)
                begin
                    mode_next = MODE_NORMAL;
                    ev        = EV_LEFT_PROG;
                end
            end
            default:
            begin
                mode_next = MODE_UNENROLLED;
            end
        endcase

        // only commit when the result register can take the transaction
        if (!((state_reg == S_DONE) && out_free))
        begin
            mode_next   = mode_reg;
            count_next  = count_reg;
            master_next = master_reg;
            cmd         = '0;
        end
    end

    // sequencer and result register
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    start_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_w[TABLE_DEPTH].tok)
                begin
                    found_next = scan_w[TABLE_DEPTH].found;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, mode_next,
                                      (count_next >= CW'(TABLE_DEPTH)),
                                      7'(count_next), ev};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_UNENROLLED;
            count_reg     <= '0;
            master_reg    <= '0;
            start_reg     <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            master_reg    <= master_next;
            start_reg     <= start_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_take)
        begin
            id_reg      <= s_axis_tdata[ID_W-1:0];
            present_reg <= s_axis_tuser;
            prog_reg    <= s_axis_tdata[32];
            forget_reg  <= s_axis_tdata[33];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
